/* rtl/sfa_pkg.sv */
package sfa_pkg;

  localparam int PARTITIONS           = 4;
  localparam int FRAMES_PER_PARTITION = 256;
  localparam int MAX_PROCESSES        = 16;
  localparam int MAX_PAGES            = 32;

  // frame bitmap is kept in rows of ROW_BITS frames
  localparam int ROW_BITS      = 32;
  localparam int ROWS_PER_PART = FRAMES_PER_PARTITION / ROW_BITS;
  localparam int FR_ROWS       = PARTITIONS * ROWS_PER_PART;
  localparam int PART_W        = $clog2(PARTITIONS);
  localparam int FRAME_W       = $clog2(FRAMES_PER_PARTITION);
  localparam int ROW_W         = $clog2(ROWS_PER_PART);
  localparam int BIT_W         = $clog2(ROW_BITS);
  localparam int FRADDR_W      = $clog2(FR_ROWS);
  localparam int SLOT_W        = $clog2(MAX_PROCESSES);
  localparam int PIDX_W        = $clog2(MAX_PAGES);
  localparam int PM_DEPTH      = MAX_PROCESSES * MAX_PAGES;
  localparam int PMADDR_W      = $clog2(PM_DEPTH);
  localparam int CNT_W         = 6;
  localparam int LIM_W         = 9;
  localparam int QDEPTH        = 2;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_DELETE = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOSPACE = 3'd1,
    ST_BADPAGE = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CFG_PAGE_SIZE   = 3'd0,
    CFG_FRAMES      = 3'd1,
    CFG_PARTITIONS  = 3'd2,
    CFG_FIXED_MODE  = 3'd3,
    CFG_FRAME_QUOTA = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [12:0] page_size;
    logic [8:0]  frames_in_use;
    logic [2:0]  partitions_in_use;
    logic        fixed_mode;
    logic [5:0]  frame_quota;
  } cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    logic        func;
    logic [31:0] process_id;
    logic [7:0]  page_number;
    logic [5:0]  need;
    logic        need_big;
  } job_t;

endpackage

/* rtl/sfa_ifs.sv */
interface sfa_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] process_id;
  logic [7:0]  page_number;
  logic [19:0] data_size;
  modport source (output valid, func, process_id, page_number, data_size, input ready);
  modport sink   (input valid, func, process_id, page_number, data_size, output ready);
endinterface

interface sfa_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [1:0] partition;
  logic [7:0] frame;
  logic       last;
  modport source (output valid, status, partition, frame, last, input ready);
  modport sink   (input valid, status, partition, frame, last, output ready);
endinterface

interface sfa_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/swap_frame_allocator.sv */
// Channel  Dir  Payload                                   Accept
// req      in   func, process_id, page_number, data_size  valid & ready
// res      out  status, partition, frame, last            valid & ready
// cfg      in   index, data (register write)              valid & ready (always ready)
//
// Front: restoring division for the frame count; takes no request until its job is queued.
// Back: each bitmap row is read, then checked; a new process counts the free frames of each
// partition in use first; delete reads the map, the row, and writes the row back per frame.
// After reset the back clears the 32 bitmap rows, one a cycle, before taking a request.
// A two-entry queue sits between front and back; the result register may stall independently.
module swap_frame_allocator (
  input  logic     clk,
  input  logic     rst,
  sfa_req_if.sink  req,
  sfa_res_if.source res,
  sfa_cfg_if.sink  cfg
);
  import sfa_pkg::*;

  cfg_t regs;
  job_t f_job;
  job_t q_job;
  logic f_push;
  logic q_full;
  logic q_valid;
  logic q_pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.page_size         <= 13'd64;
      regs.frames_in_use     <= 9'd256;
      regs.partitions_in_use <= 3'd4;
      regs.fixed_mode        <= 1'b1;
      regs.frame_quota       <= 6'd8;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_PAGE_SIZE:   regs.page_size         <= cfg.data;
        CFG_FRAMES:      regs.frames_in_use     <= cfg.data[8:0];
        CFG_PARTITIONS:  regs.partitions_in_use <= cfg.data[2:0];
        CFG_FIXED_MODE:  regs.fixed_mode        <= cfg.data[0];
        CFG_FRAME_QUOTA: regs.frame_quota       <= cfg.data[5:0];
        default: ;
      endcase
    end
  end

  sfa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (regs),
    .req      (req),
    .job      (f_job),
    .job_push (f_push),
    .job_full (q_full)
  );

  sfa_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (f_push),
    .din      (f_job),
    .pop      (q_pop),
    .dout     (q_job),
    .nonempty (q_valid),
    .full     (q_full)
  );

  sfa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (regs),
    .job       (q_job),
    .job_valid (q_valid),
    .job_pop   (q_pop),
    .res       (res)
  );

endmodule

/* rtl/sfa_ram.sv */
module sfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/sfa_fifo.sv */
module sfa_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sfa_pkg::job_t din,
  input  logic          pop,
  output sfa_pkg::job_t dout,
  output logic          nonempty,
  output logic          full
);
  import sfa_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  job_t             mem [QDEPTH];
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [PTR_W:0]   count;

  assign dout     = mem[rp];
  assign nonempty = (count != '0);
  assign full     = (count == (PTR_W + 1)'(QDEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        mem[wp] <= din;
        wp      <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      count <= count + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
    end
  end

endmodule

/* rtl/sfa_front.sv */
module sfa_front (
  input  logic          clk,
  input  logic          rst,
  input  sfa_pkg::cfg_t cfg,
  sfa_req_if.sink       req,
  output sfa_pkg::job_t job,
  output logic          job_push,
  input  logic          job_full
);
  import sfa_pkg::*;

  localparam int NUM_W = 21;
  localparam int DCNT_W = $clog2(NUM_W);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

  fstate_t           st;
  logic              func;
  logic [31:0]       pid;
  logic [7:0]        page;
  logic [NUM_W-1:0]  num;
  logic [NUM_W-1:0]  quo;
  logic [12:0]       rem;
  logic [12:0]       dvs;
  logic [DCNT_W-1:0] dcnt;
  logic [12:0]       ps;
  logic [13:0]       sh;
  logic              qbit;

  assign ps        = (cfg.page_size == '0) ? 13'd1 : cfg.page_size;
  assign sh        = {rem, num[NUM_W-1]};
  assign qbit      = (sh >= {1'b0, dvs});
  assign req.ready = (st == F_IDLE);
  assign job_push  = (st == F_PUSH) && !job_full;

  always_comb begin
    job.func        = func;
    job.process_id  = pid;
    job.page_number = page;
    job.need_big    = (quo > NUM_W'(MAX_PAGES));
    job.need        = (quo == '0) ? 6'd1 : quo[5:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= F_IDLE;
    end else begin
      unique case (st)
        F_IDLE: begin
          if (req.valid) begin
            func <= req.func;
            pid  <= req.process_id;
            page <= req.page_number;
            // ceil(size / page) as floor((size + page - 1) / page)
            num  <= NUM_W'(req.data_size) + NUM_W'(ps) - NUM_W'(1);
            dvs  <= ps;
            rem  <= '0;
            quo  <= '0;
            dcnt <= '0;
            st   <= F_DIV;
          end
        end
        F_DIV: begin
          rem  <= qbit ? 13'(sh - {1'b0, dvs}) : sh[12:0];
          quo  <= {quo[NUM_W-2:0], qbit};
          num  <= {num[NUM_W-2:0], 1'b0};
          dcnt <= dcnt + 1'b1;
          if (dcnt == DCNT_W'(NUM_W - 1)) begin
            st <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!job_full) begin
            st <= F_IDLE;
          end
        end
        default: st <= F_IDLE;
      endcase
    end
  end

endmodule

/* rtl/sfa_back.sv */
module sfa_back (
  input  logic          clk,
  input  logic          rst,
  input  sfa_pkg::cfg_t cfg,
  input  sfa_pkg::job_t job,
  input  logic          job_valid,
  output logic          job_pop,
  sfa_res_if.source     res
);
  import sfa_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_ERR, S_DEL_MAP, S_DEL_ROW, S_DEL_WR, S_DEL_DONE,
    S_HIT, S_CNT_RD, S_CNT_ACC, S_DECIDE, S_FIND_RD, S_FIND_CHK, S_FOUND, S_FIX_OUT
  } state_t;

  state_t               st;
  job_t                 cur;
  logic [SLOT_W-1:0]    slot;
  logic [SLOT_W-1:0]    free_slot;
  logic [PART_W-1:0]    p;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     i;
  logic [CNT_W-1:0]     need;
  logic [ROW_W-1:0]     ri;
  logic [PART_W-1:0]    pi;
  logic [LIM_W-1:0]     acc;
  logic [LIM_W-1:0]     bestfree;
  logic [PART_W-1:0]    best;
  logic [FRAME_W-1:0]   fsave;
  logic [FRAME_W-1:0]   first;
  logic                 grow;
  status_t              err;
  logic [FRADDR_W-1:0]  clr;

  logic [MAX_PROCESSES-1:0] ent_valid;
  logic [31:0]              ent_owner [MAX_PROCESSES];
  logic [PART_W-1:0]        ent_part  [MAX_PROCESSES];
  logic [CNT_W-1:0]         ent_cnt   [MAX_PROCESSES];

  logic               o_valid;
  status_t            o_status;
  logic [PART_W-1:0]  o_part;
  logic [FRAME_W-1:0] o_frame;
  logic               o_last;
  logic               out_free;
  logic               o_load;

  logic                fr_we;
  logic [FRADDR_W-1:0] fr_wa;
  logic [FRADDR_W-1:0] fr_ra;
  logic [ROW_BITS-1:0] fr_wd;
  logic [ROW_BITS-1:0] fr_rd;
  logic                pm_we;
  logic [PMADDR_W-1:0] pm_wa;
  logic [PMADDR_W-1:0] pm_ra;
  logic [FRAME_W-1:0]  pm_wd;
  logic [FRAME_W-1:0]  pm_rd;

  logic                hit;
  logic [SLOT_W-1:0]   hslot;
  logic                has_free;
  logic [SLOT_W-1:0]   fslot;
  logic [LIM_W-1:0]    lim;
  logic [2:0]          nparts;
  logic [ROW_BITS-1:0] row_mask;
  logic [ROW_BITS-1:0] free_bits;
  logic [BIT_W:0]      pc;
  logic [BIT_W-1:0]    idx;
  logic [LIM_W-1:0]    acc_n;
  logic [CNT_W-1:0]    qf;
  logic [CNT_W-1:0]    nf;
  logic                found_go;

  assign out_free      = !o_valid || res.ready;
  assign res.valid     = o_valid;
  assign res.status    = o_status;
  assign res.partition = o_part;
  assign res.frame     = o_frame;
  assign res.last      = o_last;
  assign job_pop       = (st == S_IDLE) && job_valid;

  assign lim    = (cfg.frames_in_use > LIM_W'(FRAMES_PER_PARTITION)) ?
                  LIM_W'(FRAMES_PER_PARTITION) : cfg.frames_in_use;
  assign nparts = (cfg.partitions_in_use > 3'(PARTITIONS)) ? 3'(PARTITIONS) :
                  cfg.partitions_in_use;
  assign qf     = (cfg.frame_quota == '0) ? 6'd1 :
                  (cfg.frame_quota > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : cfg.frame_quota;
  assign nf     = ({3'b0, qf} > bestfree) ? bestfree[CNT_W-1:0] : qf;
  assign acc_n  = acc + LIM_W'(pc);
  assign found_go = grow ? out_free : (cfg.fixed_mode || out_free);

  // result register is loaded this cycle
  always_comb begin
    unique case (st)
      S_ERR, S_HIT, S_DEL_DONE, S_FIX_OUT: o_load = out_free;
      S_FOUND: o_load = found_go && (grow || !cfg.fixed_mode);
      default: o_load = 1'b0;
    endcase
  end

  // process table search
  always_comb begin
    hit      = 1'b0;
    hslot    = '0;
    has_free = 1'b0;
    fslot    = '0;
    for (int e = 0; e < MAX_PROCESSES; e++) begin
      if (ent_valid[e]) begin
        if (!hit && ent_owner[e] == cur.process_id) begin
          hit   = 1'b1;
          hslot = SLOT_W'(e);
        end
      end else if (!has_free) begin
        has_free = 1'b1;
        fslot    = SLOT_W'(e);
      end
    end
  end

  // frames of the current row that lie below the frame limit and are free
  always_comb begin
    for (int j = 0; j < ROW_BITS; j++) begin
      row_mask[j] = (LIM_W'({ri, BIT_W'(j)}) < lim);
    end
    free_bits = ~fr_rd & row_mask;
    pc  = '0;
    idx = '0;
    for (int j = 0; j < ROW_BITS; j++) begin
      pc = pc + (BIT_W + 1)'(free_bits[j]);
    end
    for (int j = ROW_BITS - 1; j >= 0; j--) begin
      if (free_bits[j]) begin
        idx = BIT_W'(j);
      end
    end
  end

  always_comb begin
    fr_we = 1'b0;
    fr_wa = {p, ri};
    fr_wd = fr_rd | (ROW_BITS'(1) << idx);
    fr_ra = '0;
    pm_we = 1'b0;
    pm_wa = grow ? {slot, cnt[PIDX_W-1:0]} : {free_slot, i[PIDX_W-1:0]};
    pm_wd = fsave;
    pm_ra = '0;
    unique case (st)
      S_CLEAR: begin
        fr_we = 1'b1;
        fr_wa = clr;
        fr_wd = '0;
      end
      S_LOOK:    pm_ra = {hslot, cur.page_number[PIDX_W-1:0]};
      S_HIT:     pm_ra = {slot, cur.page_number[PIDX_W-1:0]};
      S_DEL_MAP: pm_ra = {slot, i[PIDX_W-1:0]};
      S_DEL_ROW: fr_ra = {p, pm_rd[FRAME_W-1:BIT_W]};
      S_DEL_WR: begin
        fr_we = 1'b1;
        fr_wa = {p, fsave[FRAME_W-1:BIT_W]};
        fr_wd = fr_rd & ~(ROW_BITS'(1) << fsave[BIT_W-1:0]);
      end
      S_CNT_RD:   fr_ra = {pi, ri};
      S_FIND_RD:  fr_ra = {p, ri};
      S_FIND_CHK: fr_we = (free_bits != '0);
      S_FOUND:    pm_we = found_go;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_CLEAR;
      clr       <= '0;
      ent_valid <= '0;
      o_valid   <= 1'b0;
    end else begin
      o_valid <= o_load || (o_valid && !res.ready);
      unique case (st)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == FRADDR_W'(FR_ROWS - 1)) begin
            st <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (job_valid) begin
            cur <= job;
            st  <= S_LOOK;
          end
        end
        S_LOOK: begin
          slot      <= hslot;
          free_slot <= fslot;
          p         <= ent_part[hslot];
          cnt       <= ent_cnt[hslot];
          i         <= '0;
          ri        <= '0;
          if (cur.func == FUNC_DELETE) begin
            if (!hit) begin
              err <= ST_UNKNOWN;
              st  <= S_ERR;
            end else if (ent_cnt[hslot] == '0) begin
              st <= S_DEL_DONE;
            end else begin
              st <= S_DEL_MAP;
            end
          end else if (hit) begin
            if (cur.page_number < {2'b0, ent_cnt[hslot]}) begin
              st <= S_HIT;
            end else if (!cfg.fixed_mode && cur.page_number == {2'b0, ent_cnt[hslot]}) begin
              if (ent_cnt[hslot] >= CNT_W'(MAX_PAGES)) begin
                err <= ST_BADPAGE;
                st  <= S_ERR;
              end else begin
                grow <= 1'b1;
                st   <= S_FIND_RD;
              end
            end else begin
              err <= ST_BADPAGE;
              st  <= S_ERR;
            end
          end else if (!has_free) begin
            err <= ST_FULL;
            st  <= S_ERR;
          end else begin
            grow     <= 1'b0;
            pi       <= '0;
            acc      <= '0;
            best     <= '0;
            bestfree <= '0;
            st       <= (nparts == '0) ? S_DECIDE : S_CNT_RD;
          end
        end
        S_ERR: begin
          if (out_free) begin
            o_status <= err;
            o_part   <= '0;
            o_frame  <= '0;
            o_last   <= 1'b1;
            st       <= S_IDLE;
          end
        end
        S_HIT: begin
          if (out_free) begin
            o_status <= ST_OK;
            o_part   <= p;
            o_frame  <= pm_rd;
            o_last   <= 1'b1;
            st       <= S_IDLE;
          end
        end
        S_DEL_MAP: st <= S_DEL_ROW;
        S_DEL_ROW: begin
          fsave <= pm_rd;
          st    <= S_DEL_WR;
        end
        S_DEL_WR: begin
          i  <= i + 1'b1;
          st <= (i + 1'b1 == cnt) ? S_DEL_DONE : S_DEL_MAP;
        end
        S_DEL_DONE: begin
          if (out_free) begin
            ent_valid[slot] <= 1'b0;
            o_status <= ST_OK;
            o_part   <= p;
            o_frame  <= '0;
            o_last   <= 1'b1;
            st       <= S_IDLE;
          end
        end
        S_CNT_RD: st <= S_CNT_ACC;
        S_CNT_ACC: begin
          if (ri == ROW_W'(ROWS_PER_PART - 1)) begin
            // strict compare: lowest partition wins a tie
            if (acc_n > bestfree) begin
              bestfree <= acc_n;
              best     <= pi;
            end
            acc <= '0;
            ri  <= '0;
            if (3'(pi) + 3'd1 == nparts) begin
              st <= S_DECIDE;
            end else begin
              pi <= pi + 1'b1;
              st <= S_CNT_RD;
            end
          end else begin
            acc <= acc_n;
            ri  <= ri + 1'b1;
            st  <= S_CNT_RD;
          end
        end
        S_DECIDE: begin
          p  <= best;
          i  <= '0;
          ri <= '0;
          if (bestfree == '0) begin
            err <= ST_NOSPACE;
            st  <= S_ERR;
          end else if (cfg.fixed_mode) begin
            need <= nf;
            st   <= S_FIND_RD;
          end else if (cur.need_big || {3'b0, cur.need} > bestfree) begin
            err <= ST_NOSPACE;
            st  <= S_ERR;
          end else begin
            need <= cur.need;
            st   <= S_FIND_RD;
          end
        end
        S_FIND_RD: st <= S_FIND_CHK;
        S_FIND_CHK: begin
          if (free_bits != '0) begin
            fsave <= {ri, idx};
            st    <= S_FOUND;
          end else if (ri == ROW_W'(ROWS_PER_PART - 1)) begin
            err <= ST_NOSPACE;
            st  <= S_ERR;
          end else begin
            ri <= ri + 1'b1;
            st <= S_FIND_RD;
          end
        end
        S_FOUND: begin
          if (found_go) begin
            if (grow) begin
              ent_cnt[slot] <= cnt + 1'b1;
              o_status <= ST_OK;
              o_part   <= p;
              o_frame  <= fsave;
              o_last   <= 1'b1;
              st       <= S_IDLE;
            end else begin
              if (i == '0) begin
                first <= fsave;
              end
              if (!cfg.fixed_mode) begin
                o_status <= ST_OK;
                o_part   <= p;
                o_frame  <= fsave;
                o_last   <= (i + 1'b1 == need);
              end
              if (i + 1'b1 == need) begin
                ent_valid[free_slot] <= 1'b1;
                ent_owner[free_slot] <= cur.process_id;
                ent_part[free_slot]  <= p;
                ent_cnt[free_slot]   <= need;
                st <= cfg.fixed_mode ? S_FIX_OUT : S_IDLE;
              end else begin
                i  <= i + 1'b1;
                ri <= '0;
                st <= S_FIND_RD;
              end
            end
          end
        end
        S_FIX_OUT: begin
          if (out_free) begin
            o_status <= ST_OK;
            o_part   <= p;
            o_frame  <= first;
            o_last   <= 1'b1;
            st       <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  sfa_ram #(.WIDTH(ROW_BITS), .DEPTH(FR_ROWS)) u_frame_ram (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_wa),
    .wdata (fr_wd),
    .raddr (fr_ra),
    .rdata (fr_rd)
  );

  sfa_ram #(.WIDTH(FRAME_W), .DEPTH(PM_DEPTH)) u_page_map (
    .clk   (clk),
    .we    (pm_we),
    .waddr (pm_wa),
    .wdata (pm_wd),
    .raddr (pm_ra),
    .rdata (pm_rd)
  );

  a_clear_no_pop: assert property (@(posedge clk) disable iff (rst)
    st == S_CLEAR |-> !job_pop)
    else $error("request taken during bitmap clear");

  a_pop_to_look: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> st == S_LOOK)
    else $error("popped request not looked up");

  a_one_new_entry: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> $countones(ent_valid) <= $past($countones(ent_valid)) + 1)
    else $error("more than one table entry created at once");

  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !res.ready) |=> $stable(o_frame) && $stable(o_status))
    else $error("pending result overwritten");

endmodule

/* dv/swap_frame_allocator_tb.sv */
`timescale 1ns / 100ps

module swap_frame_allocator_tb;
  import sfa_pkg::*;

  typedef struct {
    logic        func;
    logic [31:0] pid;
    logic [7:0]  page;
    logic [19:0] size;
  } alloc_req_t;

  typedef struct {
    status_t    st;
    logic [1:0] part;
    logic [7:0] frame;
    logic       last;
  } alloc_res_t;

  logic clk;
  logic rst;

  sfa_req_if req_if();
  sfa_res_if res_if();
  sfa_cfg_if cfg_if();

  swap_frame_allocator dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  // mirror of the block's registers and tables
  logic [12:0] cfg_page;
  logic [8:0]  cfg_frames;
  logic [2:0]  cfg_parts;
  logic        cfg_fixed;
  logic [5:0]  cfg_quota;
  bit          frame_used [PARTITIONS][FRAMES_PER_PARTITION];
  bit          ent_valid  [MAX_PROCESSES];
  logic [31:0] ent_owner  [MAX_PROCESSES];
  logic [1:0]  ent_part   [MAX_PROCESSES];
  int          ent_cnt    [MAX_PROCESSES];
  logic [7:0]  page_frame [MAX_PROCESSES][MAX_PAGES];

  alloc_req_t  pend_q[$];
  alloc_res_t  alloc_exp_q[$];
  logic [31:0] pid_pool[20];

  int  errors;
  int  snd_pct, rcv_pct;
  int  hold_cnt, pressure_req, pressure_seen;
  int  quiet_cycles;
  logic req_fire;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void add_result(status_t st, int part, int frame, bit last);
    alloc_res_t r;
    r.st    = st;
    r.part  = part[1:0];
    r.frame = frame[7:0];
    r.last  = last;
    alloc_exp_q.push_back(r);
  endfunction

  function automatic int first_free(int p, int lim);
    for (int i = 0; i < lim; i++)
      if (!frame_used[p][i]) return i;
    return -1;
  endfunction

  task automatic predict_alloc(alloc_req_t r);
    int slot, fslot, p, cnt, best, bestfree, need, ps, lim, nparts, nfree, f;
    slot  = -1;
    fslot = -1;
    for (int e = 0; e < MAX_PROCESSES; e++) begin
      if (ent_valid[e]) begin
        if (slot < 0 && ent_owner[e] == r.pid) slot = e;
      end else if (fslot < 0) begin
        fslot = e;
      end
    end
    lim    = (cfg_frames > FRAMES_PER_PARTITION) ? FRAMES_PER_PARTITION : cfg_frames;
    nparts = (cfg_parts > PARTITIONS) ? PARTITIONS : cfg_parts;

    if (r.func == FUNC_DELETE) begin
      if (slot < 0) begin
        add_result(ST_UNKNOWN, 0, 0, 1);
      end else begin
        p = ent_part[slot];
        for (int i = 0; i < ent_cnt[slot]; i++) frame_used[p][page_frame[slot][i]] = 0;
        ent_valid[slot] = 0;
        add_result(ST_OK, p, 0, 1);
      end
      return;
    end

    if (slot >= 0) begin
      p   = ent_part[slot];
      cnt = ent_cnt[slot];
      if (r.page < cnt) begin
        add_result(ST_OK, p, page_frame[slot][r.page], 1);
      end else if (!cfg_fixed && r.page == cnt) begin
        if (cnt >= MAX_PAGES) begin
          add_result(ST_BADPAGE, 0, 0, 1);
        end else begin
          f = first_free(p, lim);
          if (f < 0) begin
            add_result(ST_NOSPACE, 0, 0, 1);
          end else begin
            frame_used[p][f]       = 1;
            page_frame[slot][cnt]  = f[7:0];
            ent_cnt[slot]          = cnt + 1;
            add_result(ST_OK, p, f, 1);
          end
        end
      end else begin
        add_result(ST_BADPAGE, 0, 0, 1);
      end
      return;
    end

    // new process: partition with most free frames, lowest wins ties
    best     = 0;
    bestfree = 0;
    for (int i = 0; i < nparts; i++) begin
      nfree = 0;
      for (int j = 0; j < lim; j++) if (!frame_used[i][j]) nfree++;
      if (nfree > bestfree) begin
        bestfree = nfree;
        best     = i;
      end
    end
    if (fslot < 0) begin
      add_result(ST_FULL, 0, 0, 1);
      return;
    end
    if (bestfree == 0) begin
      add_result(ST_NOSPACE, 0, 0, 1);
      return;
    end
    if (cfg_fixed) begin
      need = (cfg_quota == 0) ? 1 : cfg_quota;
      if (need > MAX_PAGES) need = MAX_PAGES;
      if (need > bestfree) need = bestfree;
    end else begin
      ps   = (cfg_page == 0) ? 1 : cfg_page;
      need = (int'(r.size) + ps - 1) / ps;
      if (need == 0) need = 1;
      if (need > bestfree || need > MAX_PAGES) begin
        add_result(ST_NOSPACE, 0, 0, 1);
        return;
      end
    end
    for (int i = 0; i < need; i++) begin
      f = first_free(best, lim);
      frame_used[best][f]    = 1;
      page_frame[fslot][i]   = f[7:0];
    end
    ent_valid[fslot] = 1;
    ent_owner[fslot] = r.pid;
    ent_part[fslot]  = best[1:0];
    ent_cnt[fslot]   = need;
    if (cfg_fixed) begin
      add_result(ST_OK, best, page_frame[fslot][0], 1);
    end else begin
      for (int i = 0; i < need; i++)
        add_result(ST_OK, best, page_frame[fslot][i], i + 1 == need);
    end
  endtask

  // request driver
  always @(negedge clk) begin
    alloc_req_t it;
    if (rst) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_fire) begin
      if (pend_q.size() > 0 && $urandom_range(99) >= snd_pct) begin
        it = pend_q.pop_front();
        req_if.valid       <= 1'b1;
        req_if.func        <= it.func;
        req_if.process_id  <= it.pid;
        req_if.page_number <= it.page;
        req_if.data_size   <= it.size;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // result receiver, with an optional long hold-off
  always @(negedge clk) begin
    if (pressure_req != pressure_seen) begin
      pressure_seen <= pressure_req;
      hold_cnt      <= 3000;
      res_if.ready  <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt     <= hold_cnt - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= rcv_pct);
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    alloc_req_t r;
    alloc_res_t e;
    req_fire <= req_if.valid && req_if.ready && !rst;
    if (!rst) begin
      if (req_if.valid && req_if.ready) begin
        r.func = req_if.func;
        r.pid  = req_if.process_id;
        r.page = req_if.page_number;
        r.size = req_if.data_size;
        predict_alloc(r);
      end
      if (res_if.valid && res_if.ready) begin
        if (alloc_exp_q.size() == 0) begin
          $display("%0t: unexpected result st=%0d part=%0d frame=%0d last=%0d", $time,
                   res_if.status, res_if.partition, res_if.frame, res_if.last);
          errors++;
        end else begin
          e = alloc_exp_q.pop_front();
          if (res_if.status !== e.st || res_if.partition !== e.part ||
              res_if.frame !== e.frame || res_if.last !== e.last) begin
            $display("%0t: mismatch expected st=%0d part=%0d frame=%0d last=%0d, got st=%0d part=%0d frame=%0d last=%0d",
                     $time, e.st, e.part, e.frame, e.last,
                     res_if.status, res_if.partition, res_if.frame, res_if.last);
            errors++;
          end
        end
      end
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [12:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_PAGE_SIZE:   cfg_page   = val;
      CFG_FRAMES:      cfg_frames = val[8:0];
      CFG_PARTITIONS:  cfg_parts  = val[2:0];
      CFG_FIXED_MODE:  cfg_fixed  = val[0];
      CFG_FRAME_QUOTA: cfg_quota  = val[5:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic configure(int pg, int fr, int pa, int fx, int qu, int mode);
    write_reg(CFG_PAGE_SIZE, 13'(pg));
    write_reg(CFG_FRAMES, 13'(fr));
    write_reg(CFG_PARTITIONS, 13'(pa));
    write_reg(CFG_FIXED_MODE, 13'(fx));
    write_reg(CFG_FRAME_QUOTA, 13'(qu));
    snd_pct = (mode == 1) ? 48 : (mode == 3) ? 38 : 0;
    rcv_pct = (mode == 2) ? 48 : (mode == 3) ? 38 : 0;
  endtask

  task automatic push_req(logic func, logic [31:0] pid, logic [7:0] page, logic [19:0] size);
    alloc_req_t it;
    it.func = func;
    it.pid  = pid;
    it.page = page;
    it.size = size;
    pend_q.push_back(it);
  endtask

  task automatic push_mix(int n);
    int k;
    logic [31:0] pid;
    logic [7:0]  page;
    logic [19:0] size;
    for (int i = 0; i < n; i++) begin
      k    = $urandom_range(99);
      pid  = (k < 4) ? $urandom() : pid_pool[$urandom_range(19)];
      page = (k < 15) ? 8'($urandom_range(255)) : 8'($urandom_range(0, 12));
      size = (k % 4 == 0) ? 20'($urandom_range(0, 20'hFFFFF)) : 20'($urandom_range(0, 640));
      push_req((k < 24) ? FUNC_DELETE : FUNC_WRITE, pid, page, size);
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pend_q.size() != 0 || req_if.valid || alloc_exp_q.size() != 0);
    repeat (100) @(negedge clk);
  endtask

  initial begin
    errors        = 0;
    snd_pct       = 0;
    rcv_pct       = 0;
    hold_cnt      = 0;
    pressure_req  = 0;
    pressure_seen = 0;
    quiet_cycles  = 0;
    req_fire      = 1'b0;
    cfg_page      = 64;
    cfg_frames    = 256;
    cfg_parts     = 4;
    cfg_fixed     = 1;
    cfg_quota     = 8;
    foreach (frame_used[p, f]) frame_used[p][f] = 0;
    foreach (ent_valid[e]) ent_valid[e] = 0;
    pid_pool[0] = 32'h0;
    pid_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 20; i++) pid_pool[i] = $urandom();

    req_if.valid       = 1'b0;
    req_if.func        = FUNC_WRITE;
    req_if.process_id  = '0;
    req_if.page_number = '0;
    req_if.data_size   = '0;
    res_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = CFG_PAGE_SIZE;
    cfg_if.data        = '0;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings, fixed quota: hits, misses, bad pages, table full
    push_req(FUNC_WRITE, pid_pool[0], 0, 0);
    push_req(FUNC_WRITE, pid_pool[1], 8'hFF, 20'hFFFFF);
    push_req(FUNC_WRITE, pid_pool[0], 7, 0);
    push_req(FUNC_WRITE, pid_pool[0], 8, 0);
    push_req(FUNC_WRITE, pid_pool[1], 8'hFF, 0);
    push_req(FUNC_DELETE, 32'h1234_5678, 0, 0);
    push_req(FUNC_DELETE, pid_pool[0], 0, 0);
    push_req(FUNC_DELETE, pid_pool[0], 0, 0);
    for (int i = 2; i < 18; i++) push_req(FUNC_WRITE, pid_pool[i], 0, 0);
    drain();

    // global mode: one-frame, largest request, overflow and growth past the page limit
    configure(64, 256, 4, 0, 8, 0);
    for (int i = 1; i < 18; i++) push_req(FUNC_DELETE, pid_pool[i], 0, 0);
    push_req(FUNC_WRITE, pid_pool[2], 0, 0);
    push_req(FUNC_WRITE, pid_pool[3], 0, 2048);
    push_req(FUNC_WRITE, pid_pool[3], 32, 0);
    push_req(FUNC_WRITE, pid_pool[4], 0, 2049);
    push_req(FUNC_WRITE, pid_pool[2], 1, 0);
    push_req(FUNC_WRITE, pid_pool[2], 3, 0);
    push_mix(90);
    drain();

    // tiny single partition: running out of frames
    configure(1, 8, 1, 0, 8, 1);
    push_mix(40);
    drain();

    // no partitions, no frames, zero quota
    configure(13'h1FFF, 0, 0, 1, 0, 0);
    push_mix(10);
    drain();

    // settings beyond the parameters, with a long receiver hold-off
    configure(4096, 511, 7, 1, 63, 2);
    pressure_req = 1;
    push_mix(100);
    drain();

    // frames_in_use reduced below frames still held; page size zero
    configure(0, 40, 2, 0, 32, 3);
    push_mix(80);
    drain();

    configure(8191, 256, 4, 1, 32, 0);
    push_mix(90);
    drain();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
